[rtl/edp_pkg.sv]
// Shared constants and types of the edge detection pixel pipeline.
package edp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int THR_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_VAL_W  = 11;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(512);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(512);
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(10);
  localparam logic [PIX_W-1:0] PIX_MAX      = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  // Window entry k holds row k/3 (oldest first) and column k%3 (oldest first).
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] bcol;
    logic             blur_calc;
    logic             emit;
    logic             lap_int;
    logic             last;
  } item_t;

endpackage

[rtl/edp_ram.sv]
// Generic simple dual-port RAM with a registered read port.
module edp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/edp_linewin.sv]
// Two-row line memory and 3x3 sliding window for one filter stage.
module edp_linewin (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [edp_pkg::COL_W-1:0] rd_col_i,
  input  logic                      wr_en_i,
  input  logic [edp_pkg::COL_W-1:0] wr_col_i,
  input  logic [edp_pkg::PIX_W-1:0] wr_val_i,
  output edp_pkg::win_t             win_o
);
  import edp_pkg::*;

  // One memory word per column holds the two previous rows: {older, newer}.
  logic [2*PIX_W-1:0] rdata;
  logic [PIX_W-1:0]   col_in [3];
  win_t               win_d, win_q;

  edp_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_col_i),
    .wdata_i({rdata[PIX_W-1:0], wr_val_i}),
    .re_i   (rd_en_i),
    .raddr_i(rd_col_i),
    .rdata_o(rdata)
  );

  always_comb begin
    col_in[0] = rdata[2*PIX_W-1:PIX_W];
    col_in[1] = rdata[PIX_W-1:0];
    col_in[2] = wr_val_i;
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]     = win_q[i*3+1];
      win_d[i*3 + 1] = win_q[i*3+2];
      win_d[i*3 + 2] = col_in[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (wr_en_i) begin
      win_q <= win_d;
    end
  end

  assign win_o = win_d;

endmodule

[rtl/edp_ctrl.sv]
// Configuration registers, raster counters and per-pixel decisions.
module edp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [edp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [edp_pkg::CFG_VAL_W-1:0] cfg_value_i,
  input  logic                          in_fire_i,
  input  logic [edp_pkg::PIX_W-1:0]     red_i,
  input  logic [edp_pkg::PIX_W-1:0]     green_i,
  input  logic [edp_pkg::PIX_W-1:0]     blue_i,
  input  logic                          drain_i,
  output logic                          take_o,
  output edp_pkg::item_t                item_o,
  output logic [edp_pkg::THR_W-1:0]     thr_o
);
  import edp_pkg::*;

  logic [DIM_W-1:0] width_q, height_q, w, h;
  logic [THR_W-1:0] thr_q;
  logic [COL_W-1:0] col_q, ocol_q;
  logic [DIM_W-1:0] row_q, orow_q;
  logic [DIM_W-1:0] col_ext, ocol_ext;
  logic             cfg_fire, restart_cfg;
  logic             in_frame, gray_pix, col_wrap, ocol_wrap;
  logic [9:0]       rgb_sum;
  logic [19:0]      div_prod;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign restart_cfg = cfg_fire && (cfg_idx_e'(cfg_index_i) == CFG_IMAGE_WIDTH ||
                                    cfg_idx_e'(cfg_index_i) == CFG_IMAGE_HEIGHT);

  always_comb begin
    w = width_q;
    if (width_q < DIM_W'(MIN_DIM)) begin
      w = DIM_W'(MIN_DIM);
    end else if (width_q > DIM_W'(MAX_WIDTH)) begin
      w = DIM_W'(MAX_WIDTH);
    end
    h = height_q;
    if (height_q < DIM_W'(MIN_DIM)) begin
      h = DIM_W'(MIN_DIM);
    end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
      h = DIM_W'(MAX_HEIGHT);
    end
  end

  assign col_ext   = DIM_W'(col_q);
  assign ocol_ext  = DIM_W'(ocol_q);
  assign col_wrap  = (col_ext + 1'b1) >= w;
  assign ocol_wrap = (ocol_ext + 1'b1) >= w;
  assign in_frame  = row_q < h;

  // A drain before the frame's last pixel is swallowed without effect.
  assign take_o = in_fire_i && !(in_frame && drain_i);

  assign gray_pix = in_frame && (row_q != '0) && ((row_q + 1'b1) < h) &&
                    (col_q != '0) && ((col_ext + 1'b1) < w);

  // Division by three as a multiply by the scaled reciprocal; exact for all sums up to 765.
  assign rgb_sum  = 10'(red_i) + 10'(green_i) + 10'(blue_i);
  assign div_prod = 20'(rgb_sum) * 20'd683;

  always_comb begin
    item_o.gray      = gray_pix ? div_prod[18:11] : '0;
    item_o.col       = col_q;
    item_o.bcol      = (col_q == '0) ? COL_W'(w - 1'b1) : col_q - 1'b1;
    item_o.blur_calc = (col_q >= COL_W'(2)) && (row_q >= DIM_W'(2)) &&
                       ((row_q + 1'b1) <= h);
    item_o.emit      = (row_q > DIM_W'(2)) ||
                       ((row_q == DIM_W'(2)) && (col_q >= COL_W'(2)));
    item_o.lap_int   = (orow_q != '0) && ((orow_q + 1'b1) < h) &&
                       (ocol_q != '0) && ((ocol_ext + 1'b1) < w);
    item_o.last      = item_o.emit && ocol_wrap && ((orow_q + 1'b1) >= h);
  end

  assign thr_o = thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      thr_q    <= THR_RESET;
      col_q    <= '0;
      row_q    <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:    width_q  <= cfg_value_i[DIM_W-1:0];
          CFG_IMAGE_HEIGHT:   height_q <= cfg_value_i[DIM_W-1:0];
          CFG_EDGE_THRESHOLD: thr_q    <= cfg_value_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (restart_cfg || (take_o && item_o.last)) begin
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else if (take_o) begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
        if (item_o.emit) begin
          if (ocol_wrap) begin
            ocol_q <= '0;
            orow_q <= orow_q + 1'b1;
          end else begin
            ocol_q <= ocol_q + 1'b1;
          end
        end
      end
    end
  end

endmodule

[rtl/edge_detect_pixel_pipeline.sv]
// Top level: gray, Gaussian blur, Laplacian magnitude and threshold over raster pixels.
// Throughput: one transaction per cycle while the skid stage is empty; each stage has
// its own line memory with one read and one write port, used once per pixel.
// A result passes the b, c and output registers after the pixel that completes it; the
// result for pixel q comes with pixel q + 2W + 2, so 2W + 2 drains flush a frame.
// Reset clears counters and windows and loads the default configuration; line memories
// are not cleared.
module edge_detect_pixel_pipeline (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [edp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [edp_pkg::CFG_VAL_W-1:0] cfg_value_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [edp_pkg::PIX_W-1:0]     red_i,
  input  logic [edp_pkg::PIX_W-1:0]     green_i,
  input  logic [edp_pkg::PIX_W-1:0]     blue_i,
  input  logic                          drain_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [edp_pkg::PIX_W-1:0]     edge_pixel_o,
  output logic                          frame_last_o
);
  import edp_pkg::*;

  logic             en, in_fire, take;
  item_t            item, b_q;
  logic             b_vld_q, c_vld_q;
  logic [COL_W-1:0] c_bcol_q;
  logic [PIX_W-1:0] c_blur_q, blur_d;
  logic             c_emit_q, c_lap_q, c_last_q;
  logic [THR_W-1:0] thr;
  win_t             gwin, bwin;
  logic [11:0]      gsum;
  logic [9:0]       nsum, csum, diff;
  logic [PIX_W-1:0] edge_mag, pix_d;
  logic             new_res;
  logic             out_vld_q, skid_vld_q;
  logic [PIX_W-1:0] out_pix_q, skid_pix_q;
  logic             out_last_q, skid_last_q;

  // The pipeline halts only when the skid stage already holds a waiting result.
  assign en         = !skid_vld_q;
  assign in_ready_o = en;
  assign in_fire    = in_valid_i && in_ready_o;

  edp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_value_i(cfg_value_i),
    .in_fire_i  (in_fire),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .drain_i    (drain_i),
    .take_o     (take),
    .item_o     (item),
    .thr_o      (thr)
  );

  edp_linewin u_gray (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (take),
    .rd_col_i(item.col),
    .wr_en_i (en && b_vld_q),
    .wr_col_i(b_q.col),
    .wr_val_i(b_q.gray),
    .win_o   (gwin)
  );

  assign gsum = 12'(gwin[0]) + {3'b0, gwin[1], 1'b0} + 12'(gwin[2]) +
                {3'b0, gwin[3], 1'b0} + {2'b0, gwin[4], 2'b0} + {3'b0, gwin[5], 1'b0} +
                12'(gwin[6]) + {3'b0, gwin[7], 1'b0} + 12'(gwin[8]);
  assign blur_d = b_q.blur_calc ? gsum[11:4] : '0;

  edp_linewin u_blur (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (en && b_vld_q),
    .rd_col_i(b_q.bcol),
    .wr_en_i (en && c_vld_q),
    .wr_col_i(c_bcol_q),
    .wr_val_i(c_blur_q),
    .win_o   (bwin)
  );

  assign nsum     = 10'(bwin[1]) + 10'(bwin[3]) + 10'(bwin[5]) + 10'(bwin[7]);
  assign csum     = {bwin[4], 2'b0};
  assign diff     = (nsum >= csum) ? nsum - csum : csum - nsum;
  assign edge_mag = (diff > 10'(PIX_MAX)) ? PIX_MAX : diff[PIX_W-1:0];
  assign pix_d    = (c_lap_q && (THR_W'(edge_mag) >= thr)) ? PIX_MAX : '0;
  assign new_res  = en && c_vld_q && c_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= take;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q      <= item;
      c_bcol_q <= b_q.bcol;
      c_blur_q <= blur_d;
      c_emit_q <= b_q.emit;
      c_lap_q  <= b_q.lap_int;
      c_last_q <= b_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_ready_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (new_res) begin
      if (out_vld_q && !out_ready_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_ready_i) begin
        out_pix_q  <= skid_pix_q;
        out_last_q <= skid_last_q;
      end
    end else if (new_res) begin
      if (out_vld_q && !out_ready_i) begin
        skid_pix_q  <= pix_d;
        skid_last_q <= c_last_q;
      end else begin
        out_pix_q  <= pix_d;
        out_last_q <= c_last_q;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign edge_pixel_o = out_pix_q;
  assign frame_last_o = out_last_q;

endmodule

[verif/edp_checker.sv]
// Checker for the edge detection pipeline: predicts edge pixels and compares them.
`timescale 1ns / 100ps
module edp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [edp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [edp_pkg::CFG_VAL_W-1:0] cfg_value_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [edp_pkg::PIX_W-1:0]     red_i,
  input  logic [edp_pkg::PIX_W-1:0]     green_i,
  input  logic [edp_pkg::PIX_W-1:0]     blue_i,
  input  logic                          drain_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [edp_pkg::PIX_W-1:0]     edge_pixel_i,
  input  logic                          frame_last_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            edges_seen_o,
  output int                            frames_seen_o
);
  import edp_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } edge_res_t;

  edge_res_t edge_q[$];

  logic [DIM_W-1:0] width_q, height_q;
  logic [THR_W-1:0] thr_q;
  int col_q, row_q, out_cnt_q;
  // Stage 0 is gray, stage 1 is blur.
  logic [PIX_W-1:0] lines_q [2][2*MAX_WIDTH];
  logic [PIX_W-1:0] win_q   [2][9];

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic shift_in(input int stg, input int col, input logic [PIX_W-1:0] val);
    int c;
    logic [PIX_W-1:0] top, mid;
    c = col % MAX_WIDTH;
    top = lines_q[stg][MAX_WIDTH + c];
    mid = lines_q[stg][c];
    lines_q[stg][MAX_WIDTH + c] = mid;
    lines_q[stg][c] = val;
    for (int i = 0; i < 3; i++) begin
      win_q[stg][i*3]   = win_q[stg][i*3+1];
      win_q[stg][i*3+1] = win_q[stg][i*3+2];
    end
    win_q[stg][2] = top;
    win_q[stg][5] = mid;
    win_q[stg][8] = val;
  endtask

  task automatic predict_pixel(input logic [7:0] r, g, b, input logic drn);
    int w, h, total, t, rr, cc, s, lr, lc, d;
    logic [PIX_W-1:0] gray, blur, pix;
    logic last;
    edge_res_t res;
    w = clamp_dim(int'(width_q), MAX_WIDTH);
    h = clamp_dim(int'(height_q), MAX_HEIGHT);
    total = w * h;
    rr = row_q;
    cc = col_q;
    t = rr * w + cc;
    gray = '0;
    blur = '0;
    pix = '0;
    last = 1'b0;
    if (t < total && drn) return;
    if (t < total && rr >= 1 && rr + 1 < h && cc >= 1 && cc + 1 < w)
      gray = PIX_W'((int'(r) + int'(g) + int'(b)) / 3);
    shift_in(0, cc, gray);
    if (cc >= 2 && rr >= 2 && rr + 1 <= h) begin
      s = win_q[0][0] + 2*win_q[0][1] + win_q[0][2] + 2*win_q[0][3] + 4*win_q[0][4]
        + 2*win_q[0][5] + win_q[0][6] + 2*win_q[0][7] + win_q[0][8];
      blur = PIX_W'(s >> 4);
    end
    shift_in(1, (cc == 0) ? w - 1 : cc - 1, blur);
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    if (t < 2*w + 2) return;
    lr = out_cnt_q / w;
    lc = out_cnt_q % w;
    if (lr >= 1 && lr + 1 < h && lc >= 1 && lc + 1 < w) begin
      d = int'(win_q[1][1]) + int'(win_q[1][3]) + int'(win_q[1][5]) + int'(win_q[1][7])
        - 4 * int'(win_q[1][4]);
      if (d < 0) d = -d;
      if (d > 255) d = 255;
      pix = (d >= int'(thr_q)) ? PIX_MAX : '0;
    end
    out_cnt_q++;
    if (out_cnt_q >= total) begin
      last = 1'b1;
      col_q = 0;
      row_q = 0;
      out_cnt_q = 0;
    end
    res.pix = pix;
    res.last = last;
    edge_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_res_t exp_res;
    if (!rst_ni) begin
      width_q = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      thr_q = THR_RESET;
      col_q = 0;
      row_q = 0;
      out_cnt_q = 0;
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 9; i++) win_q[s][i] = '0;
        for (int i = 0; i < 2*MAX_WIDTH; i++) lines_q[s][i] = '0;
      end
      edge_q.delete();
      errors_o = 0;
      edges_seen_o = 0;
      frames_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH: begin
            width_q = cfg_value_i;
            col_q = 0; row_q = 0; out_cnt_q = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_q = cfg_value_i;
            col_q = 0; row_q = 0; out_cnt_q = 0;
          end
          CFG_EDGE_THRESHOLD: thr_q = cfg_value_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_pixel(red_i, green_i, blue_i, drain_i);
      if (out_valid_i && out_ready_i) begin
        edges_seen_o++;
        if (frame_last_i) frames_seen_o++;
        if (edge_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result edge_pixel=%0d frame_last=%0b",
                   $time, edge_pixel_i, frame_last_i);
        end else begin
          exp_res = edge_q.pop_front();
          if (edge_pixel_i !== exp_res.pix) begin
            errors_o++;
            $display("%0t: edge_pixel expected %0d actual %0d",
                     $time, exp_res.pix, edge_pixel_i);
          end
          if (frame_last_i !== exp_res.last) begin
            errors_o++;
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, exp_res.last, frame_last_i);
          end
        end
      end
    end
    pending_o = edge_q.size();
  end

endmodule

[verif/tb.sv]
// Testbench top: drives pixels, drains and register writes into the edge pipeline.
`timescale 1ns / 100ps
module tb;
  import edp_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic                 clk_i, rst_ni;
  logic                 cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_VAL_W-1:0] cfg_value_i;
  logic                 in_valid_i, in_ready_o;
  logic [PIX_W-1:0]     red_i, green_i, blue_i;
  logic                 drain_i;
  logic                 out_valid_o, out_ready_i;
  logic [PIX_W-1:0]     edge_pixel_o;
  logic                 frame_last_o;

  int errors, pending, edges_seen, frames_seen;
  int stall_cnt;
  int pixels_sent;
  bit quiet;

  edge_detect_pixel_pipeline u_dut (.*);

  edp_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_value_i,
    .in_valid_i, .in_ready_i(in_ready_o), .red_i, .green_i, .blue_i, .drain_i,
    .out_valid_i(out_valid_o), .out_ready_i, .edge_pixel_i(edge_pixel_o),
    .frame_last_i(frame_last_o), .errors_o(errors), .pending_o(pending),
    .edges_seen_o(edges_seen), .frames_seen_o(frames_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Output side stalls come in bursts; none in the quiet tail.
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic cfg_write(input cfg_idx_e idx, input int val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_value_i = CFG_VAL_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send(input logic [7:0] r, g, b, input logic drn);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    red_i = r;
    green_i = g;
    blue_i = b;
    drain_i = drn;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Waits for every edge pixel, then lets the last stages settle.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends one frame of w*h pixels with stray early drains, then the flush.
  task automatic run_frame(input int w, input int h);
    int n;
    n = 0;
    while (n < w * h) begin
      if ($urandom_range(0, 14) == 0) begin
        send(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      end else begin
        send(pick_level(), pick_level(), pick_level(), 1'b0);
        n++;
        pixels_sent++;
      end
    end
    // Late pixels count as flush steps, their color is dropped.
    for (int i = 0; i < 2*w + 2; i++)
      send(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic set_frame(input int w, input int h, input int thr);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
    cfg_write(CFG_EDGE_THRESHOLD, thr);
  endtask

  initial begin
    int w, h, thr;
    int thr_pick[6] = '{0, 1, 255, 256, 511, 10};
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_IMAGE_WIDTH;
    cfg_value_i = '0;
    in_valid_i = 1'b0;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    drain_i = 1'b0;
    quiet = 1'b0;
    pixels_sent = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: 5x5 with extreme colors, threshold zero, then out-of-range sizes.
    set_frame(5, 5, 0);
    cfg_write(CFG_UNUSED, 2047);
    for (int i = 0; i < 25; i++) begin
      w = (i % 3 == 0) ? 255 : 0;
      send(8'(w), (i % 2) ? 8'hFF : 8'h00, (i % 5 == 2) ? 8'hFF : 8'h00, 1'b0);
      pixels_sent++;
    end
    send(8'hFF, 8'hFF, 8'hFF, 1'b1);
    for (int i = 0; i < 12; i++) send(8'hAA, 8'h55, 8'hFF, 1'(i % 2));
    wait_idle();
    set_frame(0, 2, 256);
    run_frame(3, 3);
    wait_idle();

    // Size write in the middle of a frame restarts it.
    set_frame(6, 6, 20);
    for (int i = 0; i < 20; i++) begin
      send(pick_level(), pick_level(), pick_level(), 1'b0);
      pixels_sent++;
    end
    wait_idle();
    cfg_write(CFG_IMAGE_WIDTH, 7);

    // Random frames, mostly small; back to back frames share a setting.
    while (pixels_sent < 380) begin
      w = $urandom_range(3, 10);
      h = $urandom_range(3, 8);
      thr = ($urandom_range(0, 2) == 0) ? thr_pick[$urandom_range(0, 5)]
                                         : $urandom_range(0, 300);
      wait_idle();
      set_frame(w, h, thr);
      run_frame(w, h);
      if ($urandom_range(0, 2) == 0) run_frame(w, h);
    end

    // Height above the maximum is clamped; part of a frame, then a restart.
    wait_idle();
    set_frame(3, 2047, 40);
    for (int i = 0; i < 150; i++) begin
      send(pick_level(), pick_level(), pick_level(), 1'b0);
      pixels_sent++;
    end

    // Tail without idling on either side.
    wait_idle();
    quiet = 1'b1;
    set_frame(8, 6, 30);
    run_frame(8, 6);
    run_frame(8, 6);

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("tb: %0d pixels over %0d frames, %0d edge pixels checked,", pixels_sent,
             frames_seen, edges_seen);
    $display("tb: sizes 3x3 to 10x8, clamped sizes, thresholds 0 to 511, restarts and drains");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
